// File: rtl/core/bfd_pkg.sv
// bfd_pkg: shared types and constants of the binary frame deframer
// parse state codes, error codes, frame markers and the result record
// no dependencies
package bfd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_LOST     = 4'd1,
    ST_LOST_A   = 4'd2,
    ST_LOST_B   = 4'd3,
    ST_PREFIX_1 = 4'd4,
    ST_LENGTH_0 = 4'd5,
    ST_LENGTH_1 = 4'd6,
    ST_TYPE     = 4'd7,
    ST_BODY     = 4'd8,
    ST_CHECKSUM = 4'd9,
    ST_SUFFIX_0 = 4'd10,
    ST_SUFFIX_1 = 4'd11
  } bfd_state_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_PROTOCOL = 3'd1,
    ERR_BUF_FULL = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_CHANNEL  = 3'd4
  } bfd_err_t;

  localparam logic [7:0] MARK_A0 = 8'hA0;
  localparam logic [7:0] MARK_A1 = 8'hA1;
  localparam logic [7:0] MARK_CR = 8'h0D;
  localparam logic [7:0] MARK_LF = 8'h0A;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        is_type;
    logic        frame_start;
    logic [15:0] frame_length;
    logic        frame_done;
    bfd_err_t    error_code;
  } bfd_result_t;

endpackage

// File: rtl/core/bfd_if.sv
// bfd_in_if and bfd_out_if: valid/ready channels of the deframer
// request channel carries received bytes and channel events, result channel the parse result
// no dependencies
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       space_ok;

  modport source (output valid, output req_type, output rx_byte, output space_ok, input ready);
  modport sink   (input valid, input req_type, input rx_byte, input space_ok, output ready);
endinterface

interface bfd_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        is_type;
  logic        frame_start;
  logic [15:0] frame_length;
  logic        frame_done;
  logic [2:0]  error_code;

  modport source (output valid, output data_valid, output data_byte, output is_type,
                  output frame_start, output frame_length, output frame_done,
                  output error_code, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input is_type,
                  input frame_start, input frame_length, input frame_done,
                  input error_code, output ready);
endinterface

// File: rtl/core/bfd_parser.sv
// bfd_parser: frame parse state machine with length, count, checksum and accept flag
// computes the result of one request; state advances on step
// depends on bfd_pkg
module bfd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                req_type,
  input  logic [7:0]          rx_byte,
  input  logic                space_ok,
  output bfd_pkg::bfd_result_t res
);
  import bfd_pkg::*;

  bfd_state_t  state_r, state_nxt, nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        acc_r, acc_nxt;
  logic [15:0] cnt_inc;
  logic [16:0] cnt_end;

  // body bytes seen so far including this one, plus the type byte
  assign cnt_inc = cnt_r + 16'd1;
  assign cnt_end = {1'b0, cnt_inc} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      acc_r   <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    acc_nxt   = acc_r;
    res       = '0;
    nxt       = ST_LOST;
    if (req_type) begin
      state_nxt      = ST_LOST;
      res.error_code = ERR_CHANNEL;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (rx_byte == MARK_A0) nxt = ST_PREFIX_1;
        end
        ST_LOST, ST_LOST_A: begin
          nxt = (rx_byte == MARK_A0) ? ST_LOST_B : ST_LOST_A;
        end
        ST_LOST_B: begin
          if (rx_byte == MARK_A0)      nxt = ST_LOST_B;
          else if (rx_byte == MARK_A1) nxt = ST_LENGTH_0;
          else                         nxt = ST_LOST_A;
        end
        ST_PREFIX_1: begin
          if (rx_byte == MARK_A1) nxt = ST_LENGTH_0;
        end
        ST_LENGTH_0: begin
          len_nxt = {rx_byte, 8'h00};
          nxt     = ST_LENGTH_1;
        end
        ST_LENGTH_1: begin
          len_nxt = {len_r[15:8], rx_byte};
          if (len_nxt == 16'd0) begin
            acc_nxt = 1'b0;
          end else begin
            nxt = ST_TYPE;
            if (space_ok) begin
              acc_nxt          = 1'b1;
              res.frame_start  = 1'b1;
              res.frame_length = len_nxt;
            end else begin
              acc_nxt        = 1'b0;
              res.error_code = ERR_BUF_FULL;
            end
          end
        end
        ST_TYPE: begin
          if (acc_r) begin
            res.data_valid = 1'b1;
            res.data_byte  = rx_byte;
            res.is_type    = 1'b1;
          end
          cnt_nxt = '0;
          xor_nxt = rx_byte;
          nxt     = (len_r <= 16'd1) ? ST_CHECKSUM : ST_BODY;
        end
        ST_BODY: begin
          if (acc_r) begin
            res.data_valid = 1'b1;
            res.data_byte  = rx_byte;
          end
          cnt_nxt = cnt_inc;
          xor_nxt = xor_r ^ rx_byte;
          nxt     = (cnt_end >= {1'b0, len_r}) ? ST_CHECKSUM : ST_BODY;
        end
        ST_CHECKSUM: begin
          if (xor_r != rx_byte) begin
            res.error_code = ERR_CHECKSUM;
            acc_nxt        = 1'b0;
          end
          nxt = ST_SUFFIX_0;
        end
        ST_SUFFIX_0: begin
          if (rx_byte == MARK_CR) nxt = ST_SUFFIX_1;
        end
        ST_SUFFIX_1: begin
          if (rx_byte == MARK_LF) begin
            res.frame_done = acc_r;
            nxt            = ST_IDLE;
          end
        end
        default: begin
          nxt = ST_LOST_A;
        end
      endcase
      if (nxt == ST_LOST) res.error_code = ERR_PROTOCOL;
      state_nxt = nxt;
    end
  end

endmodule

// File: rtl/core/bfd_out_stage.sv
// bfd_out_stage: result register with valid/ready toward the consumer
// holds one finished result until it is taken
// depends on bfd_pkg
module bfd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  bfd_pkg::bfd_result_t res_in,
  input  logic                 out_ready,
  output logic                 out_valid,
  output bfd_pkg::bfd_result_t res_out
);
  import bfd_pkg::*;

  logic        vld_r, vld_nxt;
  bfd_result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load)           vld_nxt = 1'b1;
    else if (out_ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule

// File: rtl/core/binary_frame_deframer_top.sv
// binary_frame_deframer_top: deframer for A0 A1 / length / payload / XOR / 0D 0A frames
// request register, parser state machine and result register
// depends on bfd_pkg, bfd_if, bfd_parser, bfd_out_stage
//
// Every request (received byte or channel-error event) gives exactly one result. One
// request is taken per clock cycle as long as the consumer keeps taking results; a
// request's result reaches the result port through the request register and then the
// parser's combinational state update into the result register. The rate is set by
// the parse state loop, which updates once per request. A stalled consumer fills the
// result and request registers and then holds off new requests.
module binary_frame_deframer_top (
  input  logic     clk,
  input  logic     rst_n,
  bfd_in_if.sink   in_ch,
  bfd_out_if.source out_ch
);
  import bfd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic        req_type_r;
  logic [7:0]  rx_byte_r;
  logic        space_ok_r;
  logic        adv;
  logic        out_valid;
  bfd_result_t res, res_q;

  assign adv         = in_vld_r && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.valid && in_ch.ready) in_vld_nxt = 1'b1;
    else if (adv)                   in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_type_r <= in_ch.req_type;
      rx_byte_r  <= in_ch.rx_byte;
      space_ok_r <= in_ch.space_ok;
    end
  end

  bfd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .req_type (req_type_r),
    .rx_byte  (rx_byte_r),
    .space_ok (space_ok_r),
    .res      (res)
  );

  bfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.data_valid   = res_q.data_valid;
  assign out_ch.data_byte    = res_q.data_byte;
  assign out_ch.is_type      = res_q.is_type;
  assign out_ch.frame_start  = res_q.frame_start;
  assign out_ch.frame_length = res_q.frame_length;
  assign out_ch.frame_done   = res_q.frame_done;
  assign out_ch.error_code   = 3'(res_q.error_code);

endmodule

// File: rtl/core/bfd_checker.sv
// bfd_checker: port-level checks of the deframer result channel
// bound to binary_frame_deframer_top
// depends on bfd_if
module bfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        data_valid,
  input logic [7:0]  data_byte,
  input logic        is_type,
  input logic        frame_start,
  input logic [15:0] frame_length,
  input logic        frame_done,
  input logic [2:0]  error_code
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && data_valid |-> error_code == 3'd0 && !frame_start && !frame_done)
    else $error("payload byte together with another event");

  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !data_valid |-> data_byte == 8'd0 && !is_type)
    else $error("payload fields set without payload byte");

  a_start_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_start |-> frame_length != 16'd0 && error_code == 3'd0)
    else $error("frame start with zero length or error");

endmodule

bind binary_frame_deframer_top bfd_checker u_bfd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .data_valid   (out_ch.data_valid),
  .data_byte    (out_ch.data_byte),
  .is_type      (out_ch.is_type),
  .frame_start  (out_ch.frame_start),
  .frame_length (out_ch.frame_length),
  .frame_done   (out_ch.frame_done),
  .error_code   (out_ch.error_code)
);
